// ----- rtl/ctw_pkg.sv -----
package ctw_pkg;

    localparam int CHAR_W    = 8;
    localparam int LINE_OUT_W = 6;
    localparam int COL_OUT_W  = 8;
    localparam int ROW_IN_W   = 6;
    localparam int COL_IN_W   = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    localparam int RST_LINE_WIDTH = 80;
    localparam int RST_LINE_COUNT = 25;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT = 2'd1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_RDATA = 8'b0000_0100,
        ST_PUT   = 8'b0000_1000,
        ST_FILL  = 8'b0001_0000,
        ST_ENDL  = 8'b0010_0000,
        ST_TERM  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

endpackage

// ----- rtl/ctw_store.sv -----
module ctw_store
    import ctw_pkg::*;
#(
    parameter int DEPTH = 8256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     addr,
    input  logic [CHAR_W-1:0] wdata,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ctw_cfg.sv -----
module ctw_cfg
    import ctw_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    localparam int CW  = $clog2(MAX_COLS + 1),
    localparam int LCW = $clog2(MAX_ROWS + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [CW-1:0]          line_width,
    output logic [LCW-1:0]         line_count,
    output logic                   clear_req
);

    localparam int RST_W = (RST_LINE_WIDTH > MAX_COLS) ? MAX_COLS : RST_LINE_WIDTH;
    localparam int RST_C = (RST_LINE_COUNT > MAX_ROWS) ? MAX_ROWS : RST_LINE_COUNT;

    logic          cfg_fire;
    logic [CW-1:0] width_reg, width_next, width_sat;
    logic [LCW-1:0] count_reg, count_next, count_sat;
    logic [7:0]    w_raw;
    logic [6:0]    c_raw;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign w_raw     = cfg_data[7:0];
    assign c_raw     = cfg_data[6:0];

    always_comb begin
        priority if (w_raw == 8'd0) begin
            width_sat = CW'(1);
        end else if (9'(w_raw) > 9'(MAX_COLS)) begin
            width_sat = CW'(MAX_COLS);
        end else begin
            width_sat = CW'(w_raw);
        end
        priority if (c_raw == 7'd0) begin
            count_sat = LCW'(1);
        end else if (9'(c_raw) > 9'(MAX_ROWS)) begin
            count_sat = LCW'(MAX_ROWS);
        end else begin
            count_sat = LCW'(c_raw);
        end
    end

    always_comb begin
        width_next = width_reg;
        count_next = count_reg;
        clear_req  = 1'b0;
        if (cfg_fire) begin
            if (cfg_index == CFG_LINE_WIDTH) begin
                width_next = width_sat;
                clear_req  = 1'b1;
            end else if (cfg_index == CFG_LINE_COUNT) begin
                count_next = count_sat;
                clear_req  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= CW'(RST_W);
            count_reg <= LCW'(RST_C);
        end else begin
            width_reg <= width_next;
            count_reg <= count_next;
        end
    end

    assign line_width = width_reg;
    assign line_count = count_reg;

endmodule

// ----- rtl/ctw_ctrl.sv -----
module ctw_ctrl
    import ctw_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int TAB_STOP = 8,
    localparam int CW     = $clog2(MAX_COLS + 1),
    localparam int LCW    = $clog2(MAX_ROWS + 1),
    localparam int STRIDE = MAX_COLS + 1,
    localparam int DEPTH  = MAX_ROWS * STRIDE,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [CHAR_W-1:0]     s_char_code,
    input  logic [ROW_IN_W-1:0]   s_read_row,
    input  logic [COL_IN_W-1:0]   s_read_col,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_W-1:0]     m_read_char,
    output logic [LINE_OUT_W-1:0] m_current_line,
    output logic [COL_OUT_W-1:0]  m_current_column,
    input  logic [CW-1:0]         line_width,
    input  logic [LCW-1:0]        line_count,
    input  logic                  clear_req,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_addr,
    output logic [CHAR_W-1:0]     mem_wdata,
    input  logic [CHAR_W-1:0]     mem_rdata
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int PW = $clog2(TAB_STOP);

    state_t            state_reg, state_next;
    logic [RW-1:0]     line_reg, line_next;
    logic [CW-1:0]     cursor_reg, cursor_next;
    logic [PW-1:0]     phase_reg, phase_next, phase_inc, phase_dec;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [CHAR_W-1:0] rd_char_reg, rd_char_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic [LINE_OUT_W-1:0] out_line_reg, out_line_next;
    logic [COL_OUT_W-1:0]  out_col_reg, out_col_next;

    logic          s_fire, rd_in_range;
    logic [AW-1:0] row_sel, col_sel, addr_calc;
    logic [PW:0]   tab_pad;
    logic [CW:0]   cursor_inc_w, tab_end_w;
    logic [LCW-1:0] line_inc;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign rd_in_range = (9'(s_read_row) < 9'(MAX_ROWS)) && (9'(s_read_col) <= 9'(MAX_COLS));

    // shared cell address unit: row * stride + column
    always_comb begin
        if (state_reg == ST_IDLE) begin
            row_sel = rd_in_range ? AW'(s_read_row) : '0;
            col_sel = rd_in_range ? AW'(s_read_col) : '0;
        end else begin
            row_sel = AW'(line_reg);
            col_sel = AW'(cursor_reg);
        end
        addr_calc = AW'(row_sel * AW'(STRIDE)) + col_sel;
    end

    assign phase_inc    = (phase_reg == PW'(TAB_STOP - 1)) ? '0 : phase_reg + PW'(1);
    assign phase_dec    = (phase_reg == '0) ? PW'(TAB_STOP - 1) : phase_reg - PW'(1);
    assign tab_pad      = (PW + 1)'(TAB_STOP) - (PW + 1)'(phase_reg);
    assign cursor_inc_w = (CW + 1)'(cursor_reg) + (CW + 1)'(1);
    assign tab_end_w    = (CW + 1)'(cursor_reg) + (CW + 1)'(tab_pad);
    assign line_inc     = LCW'(line_reg) + LCW'(1);

    always_comb begin
        state_next    = state_reg;
        line_next     = line_reg;
        cursor_next   = cursor_reg;
        phase_next    = phase_reg;
        char_next     = char_reg;
        rd_ok_next    = rd_ok_reg;
        rd_char_next  = rd_char_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_valid_next  = m_valid_reg;
        out_char_next = out_char_reg;
        out_line_next = out_line_reg;
        out_col_next  = out_col_reg;
        mem_we        = 1'b0;
        mem_wdata     = CH_NUL;
        mem_addr      = addr_calc;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_addr     = clr_cnt_reg;
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_command == CMD_READ) begin
                        rd_ok_next = rd_in_range;
                        state_next = ST_RDATA;
                    end else begin
                        char_next    = s_char_code;
                        rd_char_next = CH_NUL;
                        state_next   = ST_PUT;
                    end
                end
            end
            ST_RDATA: begin
                rd_char_next = rd_ok_reg ? mem_rdata : CH_NUL;
                state_next   = ST_DONE;
            end
            ST_PUT: begin
                priority if (char_reg == CH_NEWLINE) begin
                    state_next = ST_ENDL;
                end else if (char_reg == CH_RETURN) begin
                    cursor_next = '0;
                    phase_next  = '0;
                    state_next  = ST_TERM;
                end else if (char_reg == CH_BACKSPACE) begin
                    if (cursor_reg != '0) begin
                        cursor_next = cursor_reg - CW'(1);
                        phase_next  = phase_dec;
                    end
                    state_next = ST_TERM;
                end else if (char_reg == CH_TAB) begin
                    if (tab_end_w < (CW + 1)'(line_width)) begin
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_ENDL;
                    end
                end else begin
                    mem_we      = 1'b1;
                    mem_wdata   = char_reg;
                    cursor_next = CW'(cursor_inc_w);
                    phase_next  = phase_inc;
                    if (cursor_inc_w >= (CW + 1)'(line_width)) begin
                        state_next = ST_ENDL;
                    end else begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_FILL: begin
                mem_we      = 1'b1;
                mem_wdata   = CH_SPACE;
                cursor_next = CW'(cursor_inc_w);
                phase_next  = phase_inc;
                if (phase_inc == '0) begin
                    state_next = ST_TERM;
                end
            end
            ST_ENDL: begin
                mem_we      = 1'b1;
                line_next   = (line_inc >= line_count) ? '0 : RW'(line_inc);
                cursor_next = '0;
                phase_next  = '0;
                state_next  = ST_TERM;
            end
            ST_TERM: begin
                mem_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    out_char_next = rd_char_reg;
                    out_line_next = LINE_OUT_W'(line_reg);
                    out_col_next  = COL_OUT_W'(cursor_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        if (clear_req) begin
            state_next   = ST_CLEAR;
            clr_cnt_next = '0;
            line_next    = '0;
            cursor_next  = '0;
            phase_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            line_reg    <= '0;
            cursor_reg  <= '0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            line_reg    <= line_next;
            cursor_reg  <= cursor_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        rd_ok_reg    <= rd_ok_next;
        rd_char_reg  <= rd_char_next;
        out_char_reg <= out_char_next;
        out_line_reg <= out_line_next;
        out_col_reg  <= out_col_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_read_char      = out_char_reg;
    assign m_current_line   = out_line_reg;
    assign m_current_column = out_col_reg;

endmodule

// ----- rtl/text_console_char_writer.sv -----
// Sequence: a read passes through RDATA and DONE after acceptance; a return, backspace or
// plain put through PUT, TERM and DONE; a put that ends the line (wrap, newline, tab past the
// width) adds ENDL before TERM; a tab of p spaces adds p FILL steps (one memory port, one
// cell a cycle). The sequencer holds one item at a time.
// Reset (aresetn low, synchronous) and every write to line_width or line_count start a
// clearing pass over the MAX_ROWS * (MAX_COLS + 1) cells (8256 by default), s_tready low.
module text_console_char_writer
    import ctw_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int TAB_STOP = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,  // command, char_code, read_row, read_col
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,  // read_char, current_line, current_column
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int LCW   = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_ROWS * (MAX_COLS + 1);
    localparam int AW    = $clog2(DEPTH);

    logic [CW-1:0]         line_width;
    logic [LCW-1:0]        line_count;
    logic                  clear_req;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [CHAR_W-1:0]     mem_wdata, mem_rdata;
    logic [CHAR_W-1:0]     read_char;
    logic [LINE_OUT_W-1:0] current_line;
    logic [COL_OUT_W-1:0]  current_column;

    ctw_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .line_width (line_width),
        .line_count (line_count),
        .clear_req  (clear_req)
    );

    ctw_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    ctw_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_tvalid),
        .s_ready          (s_tready),
        .s_command        (s_tdata[0]),
        .s_char_code      (s_tdata[8:1]),
        .s_read_row       (s_tdata[14:9]),
        .s_read_col       (s_tdata[22:15]),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_read_char      (read_char),
        .m_current_line   (current_line),
        .m_current_column (current_column),
        .line_width       (line_width),
        .line_count       (line_count),
        .clear_req        (clear_req),
        .mem_we           (mem_we),
        .mem_addr         (mem_addr),
        .mem_wdata        (mem_wdata),
        .mem_rdata        (mem_rdata)
    );

    assign m_tdata = {2'b00, current_column, current_line, read_char};

endmodule

// ----- rtl/ctw_checker.sv -----
module ctw_checker
    import ctw_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_TDATA_W-1:0]   m_tdata,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or input ready present right after reset");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready &&
        (cfg_index == CFG_LINE_WIDTH || cfg_index == CFG_LINE_COUNT) |=> !s_tready)
        else $error("input ready during clear after register write");

endmodule

bind text_console_char_writer ctw_checker u_ctw_checker (.*);
